// ===== src/count_min_sketch_engine_macros.svh =====
// Assertion macros shared by the count-min sketch RTL.
`ifndef COUNT_MIN_SKETCH_ENGINE_MACROS_SVH
`define COUNT_MIN_SKETCH_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CMSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CMSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cmse_pkg.sv =====
// Package: constants, codes and control structs of the count-min sketch.
`default_nettype none

package cmse_pkg;

  localparam int ROWS_DEF       = 4;
  localparam int COLUMNS_DEF    = 1024;
  localparam int COUNT_BITS_DEF = 32;

  localparam int KIND_W = 2;
  localparam int KEY_W  = 64;
  localparam int AMT_W  = 32;
  localparam int EST_W  = 32;

  // FNV-1a 64: prime is 2^40 + 0x1b3
  localparam logic [KEY_W-1:0] FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
  localparam int               FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]       FNV_PRIME_LO    = 9'h1B3;

  localparam int KEY_BYTES = KEY_W / 8;
  localparam int STEP_W    = $clog2(KEY_BYTES);

  typedef enum logic [KIND_W-1:0] {
    KIND_INC = 2'd0,
    KIND_EST = 2'd1,
    KIND_CLR = 2'd2
  } kind_t;

  typedef struct packed {
    logic              load;
    logic              hash_init;
    logic              hash_step;
    logic              mod_step;
    logic              rd;
    logic              upd;
    logic              next_row;
    logic              out_load;
    logic              clr_step;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              last_row;
    logic              clr_last;
    logic              out_valid;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/cmse_in_if.sv =====
// Input channel interface: valid/ready plus the item payload.
`default_nettype none

interface cmse_in_if import cmse_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, output kind, output key, output amount, input ready);
  modport sink   (input valid, input kind, input key, input amount, output ready);
endinterface

`default_nettype wire

// ===== src/cmse_out_if.sv =====
// Result channel interface: valid/ready plus the estimate.
`default_nettype none

interface cmse_out_if import cmse_pkg::*;;
  logic             valid;
  logic             ready;
  logic [EST_W-1:0] estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

`default_nettype wire

// ===== src/cmse_dpath.sv =====
// Datapath: hash, column reduction, counter memory, min tracking, output register.
`default_nettype none
`include "count_min_sketch_engine_macros.svh"

module cmse_dpath import cmse_pkg::*; #(
  parameter int ROWS       = ROWS_DEF,
  parameter int COLUMNS    = COLUMNS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output      sts_t              sts,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [KEY_W-1:0]  in_key,
  input  wire logic [AMT_W-1:0]  in_amount,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [EST_W-1:0]  out_estimate
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RBW   = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = CW + 1;
  localparam int EW    = (COUNT_BITS > EST_W) ? COUNT_BITS : EST_W;
  localparam int SW    = EW + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [EST_W-1:0]      OUT_MAX   = '1;

  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic [KIND_W-1:0]     kind_r;
  logic [KEY_W-1:0]      key_r;
  logic [AMT_W-1:0]      amount_r;
  logic [RBW-1:0]        row_r;
  logic [AW-1:0]         base_r;
  logic [KEY_W-1:0]      hash_r;
  logic [RW-1:0]         rem_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic [COUNT_BITS-1:0] min_r;
  logic [AW-1:0]         clr_addr_r;
  logic                  out_valid_r;
  logic [EST_W-1:0]      est_r;

  logic [KEY_W-1:0]      hash_x;
  logic [KEY_W-1:0]      hash_nxt;
  logic [RW-1:0]         rem_nxt;
  logic [AW-1:0]         addr;
  logic                  we;
  logic [SW-1:0]         sum;
  logic [COUNT_BITS-1:0] sat;
  logic [COUNT_BITS-1:0] wdata;
  logic [EW-1:0]         min_ext;
  logic [EST_W-1:0]      est_nxt;

  // one FNV-1a byte round; the prime multiply is a shift plus a 9-bit constant product
  always_comb begin
    hash_x   = hash_r ^ {{(KEY_W-8){1'b0}}, key_r[8*cmd.step +: 8]};
    hash_nxt = (hash_x << FNV_PRIME_SHIFT) + hash_x * KEY_W'(FNV_PRIME_LO);
  end

  // restoring remainder, eight hash bits per cycle, MSB first
  always_comb begin
    logic [RW-1:0] r;
    r = rem_r;
    for (int i = 0; i < 8; i++) begin
      r = {r[RW-2:0], hash_r[KEY_W-1-i]};
      if (r >= RW'(COLUMNS)) begin
        r = r - RW'(COLUMNS);
      end
    end
    rem_nxt = r;
  end

  always_comb begin
    addr  = cmd.clr_step ? clr_addr_r : base_r + AW'(rem_r[CW-1:0]);
    sum   = SW'(rdata_r) + SW'(amount_r);
    sat   = (sum > SW'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_BITS-1:0];
    we    = cmd.clr_step || (cmd.upd && (kind_r == KIND_INC));
    wdata = cmd.clr_step ? '0 : sat;
    min_ext = EW'(min_r);
    est_nxt = (min_ext > EW'(OUT_MAX)) ? OUT_MAX : min_ext[EST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        row_r <= '0;
      end else if (cmd.next_row) begin
        row_r <= row_r + RBW'(1);
      end
      if (cmd.clr_step) begin
        clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + AW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      key_r    <= in_key;
      amount_r <= in_amount;
      base_r   <= '0;
      min_r    <= COUNT_MAX;
    end else begin
      if (cmd.next_row) begin
        base_r <= base_r + AW'(COLUMNS);
      end
      if (cmd.upd && (kind_r == KIND_EST) && (rdata_r < min_r)) begin
        min_r <= rdata_r;
      end
    end
    if (cmd.hash_init) begin
      hash_r <= FNV_BASIS ^ KEY_W'(row_r);
      rem_r  <= '0;
    end else if (cmd.hash_step) begin
      hash_r <= hash_nxt;
    end else if (cmd.mod_step) begin
      hash_r <= hash_r << 8;
      rem_r  <= rem_nxt;
    end
    if (cmd.out_load) begin
      est_r <= est_nxt;
    end
  end

  always_comb begin
    sts.kind      = kind_r;
    sts.last_row  = (row_r == RBW'(ROWS - 1));
    sts.clr_last  = (clr_addr_r == AW'(DEPTH - 1));
    sts.out_valid = out_valid_r;
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = est_r;

  `CMSE_ASSERT_NOW(a_rem_range, cmd.rd, rem_r < RW'(COLUMNS), "column out of range at read")
  `CMSE_ASSERT_NOW(a_sat_no_wrap, cmd.upd && (kind_r == KIND_INC), wdata >= rdata_r,
                   "counter wrapped on increment")
  `CMSE_ASSERT_NEXT(a_clr_wrap, cmd.clr_step && sts.clr_last, clr_addr_r == '0,
                    "clear address did not wrap")

endmodule

`default_nettype wire

// ===== src/cmse_ctrl.sv =====
// Controller: sequences hash, reduction, memory access and clear sweeps.
`default_nettype none
`include "count_min_sketch_engine_macros.svh"

module cmse_ctrl import cmse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire logic out_ready,
  output      cmd_t cmd,
  input  wire sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_HASH,
    S_MOD,
    S_READ,
    S_UPD,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic              in_ready_r;
  logic              step_last;

  assign step_last = (step_r == STEP_W'(KEY_BYTES - 1));

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.step  = step_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        priority if (sts.kind == KIND_INC || sts.kind == KIND_EST) begin
          cmd.hash_init = 1'b1;
          state_nxt     = S_HASH;
        end else if (sts.kind == KIND_CLR) begin
          state_nxt = S_CLEAR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (step_last) state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (step_last) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (!sts.last_row) begin
          cmd.next_row = 1'b1;
          state_nxt    = S_ROW;
        end else if (sts.kind == KIND_EST) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!sts.out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      step_r     <= '0;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
      if (cmd.hash_step || cmd.mod_step) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  assign in_ready = in_ready_r;

  `CMSE_ASSERT_NEXT(a_accept_row, in_valid && in_ready, state_r == S_ROW,
                    "accepted transaction did not start")
  `CMSE_ASSERT_NEXT(a_hash_to_mod, (state_r == S_HASH) && step_last, state_r == S_MOD,
                    "hash rounds did not end after eight bytes")
  `CMSE_ASSERT_NOW(a_out_free, cmd.out_load, !sts.out_valid || out_ready,
                   "result loaded over a pending transaction")

endmodule

`default_nettype wire

// ===== src/count_min_sketch_engine.sv =====
// Top level of the count-min sketch engine: controller plus datapath.
// Increment: the next item is accepted once every row is done; per row a setup step,
// 8 hash rounds, 8 remainder steps, read and update through one shared hash unit.
// Estimate: result valid once every row is done, next accept after it is loaded, more on stall.
// Clear item: every counter is zeroed, one counter written per cycle; kind 3 is ignored.
// Reset (synchronous, rst_n low) starts a clearing pass over all counters, in_ready low.
`default_nettype none

module count_min_sketch_engine import cmse_pkg::*; #(
  parameter int ROWS       = ROWS_DEF,
  parameter int COLUMNS    = COLUMNS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  cmse_in_if.sink    in_chan,
  cmse_out_if.source out_chan
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  logic [EST_W-1:0] out_estimate;

  cmse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cmse_dpath #(
    .ROWS       (ROWS),
    .COLUMNS    (COLUMNS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_chan.kind),
    .in_key       (in_chan.key),
    .in_amount    (in_chan.amount),
    .out_valid    (out_valid),
    .out_ready    (out_chan.ready),
    .out_estimate (out_estimate)
  );

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid;
  assign out_chan.estimate = out_estimate;

endmodule

`default_nettype wire

// ===== verif/sketch_checker.sv =====
// Checker for the count-min sketch: tracks the counter table, predicts estimates, compares results.
`timescale 1ns / 100ps

module sketch_checker import cmse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [AMT_W-1:0]  in_amount,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [EST_W-1:0]  out_estimate,
  output int unsigned       mismatches,
  output int unsigned       pending,
  output int unsigned       checked
);

  localparam longint unsigned CELL_MAX = (COUNT_BITS_DEF >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                         ((64'd1 << COUNT_BITS_DEF) - 64'd1);
  localparam longint unsigned EST_MAX  = (64'd1 << EST_W) - 64'd1;
  localparam logic [63:0]     FNV_MULT = (64'd1 << FNV_PRIME_SHIFT) | 64'(FNV_PRIME_LO);

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [EST_W-1:0] estimate;
  } est_rec_t;

  est_rec_t        estimate_q[$];
  longint unsigned tally [ROWS_DEF][COLUMNS_DEF];
  int unsigned     n_bad;
  int unsigned     n_checked;

  initial begin
    foreach (tally[r, c]) tally[r][c] = 0;
    n_bad      = 0;
    n_checked  = 0;
  end

  // FNV-1a 64 over the key bytes, low byte first, row folded into the basis
  function automatic int unsigned sketch_column(logic [KEY_W-1:0] key, int unsigned row);
    logic [63:0] h;
    h = FNV_BASIS ^ 64'(row);
    for (int b = 0; b < KEY_BYTES; b++) begin
      h = (h ^ 64'(key[8*b +: 8])) * FNV_MULT;
    end
    return 32'(h % 64'(COLUMNS_DEF));
  endfunction

  function automatic void bump_counters(logic [KEY_W-1:0] key, logic [AMT_W-1:0] amount);
    int unsigned     c;
    longint unsigned amt;
    amt = 64'(amount);
    for (int r = 0; r < ROWS_DEF; r++) begin
      c = sketch_column(key, r);
      if (amt > CELL_MAX - tally[r][c]) begin
        tally[r][c] = CELL_MAX;
      end else begin
        tally[r][c] += amt;
      end
    end
  endfunction

  function automatic logic [EST_W-1:0] min_estimate(logic [KEY_W-1:0] key);
    longint unsigned least;
    least = CELL_MAX;
    for (int r = 0; r < ROWS_DEF; r++) begin
      if (tally[r][sketch_column(key, r)] < least) least = tally[r][sketch_column(key, r)];
    end
    if (least > EST_MAX) least = EST_MAX;
    return EST_W'(least);
  endfunction

  always @(posedge clk) begin
    est_rec_t want;
    if (!rst_n) begin
      estimate_q.delete();
    end else begin
      // results first: a query accepted on this edge cannot have its answer yet
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t: unexpected estimate %0d, no query outstanding", $time, out_estimate);
          end
        end else begin
          want = estimate_q.pop_front();
          n_checked++;
          if (out_estimate !== want.estimate) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: estimate for key %h: expected %0d, got %0d",
                       $time, want.key, want.estimate, out_estimate);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_kind)
          KIND_INC: bump_counters(in_key, in_amount);
          KIND_EST: estimate_q.push_back('{key: in_key, estimate: min_estimate(in_key)});
          KIND_CLR: foreach (tally[r, c]) tally[r][c] = 0;
          default: ;
        endcase
      end
    end
    mismatches <= n_bad;
    pending    <= estimate_q.size();
    checked    <= n_checked;
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the count-min sketch testbench: clock, reset, stimulus, result backpressure, verdict.
`timescale 1ns / 100ps

module testbench;
  import cmse_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned       POOL_SIZE   = 24;
  localparam int unsigned       PHASE_ITEMS = 400;

  logic        clk;
  logic        rst_n;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned n_inc;
  int unsigned n_clr;
  int unsigned n_skip;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  cmse_in_if  in_ch();
  cmse_out_if out_ch();

  count_min_sketch_engine dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  sketch_checker estimate_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_kind     (in_ch.kind),
    .in_key      (in_ch.key),
    .in_amount   (in_ch.amount),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_estimate(out_ch.estimate),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [AMT_W-1:0] amount);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.key    <= key;
    in_ch.amount <= amount;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (kind)
      KIND_INC:    n_inc++;
      KIND_CLR:    n_clr++;
      KIND_UNUSED: n_skip++;
      default: ;
    endcase
  endtask

  // extra edge first: the checker's count is registered and lags the transaction
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 93) return $urandom_range(1000);
    if (r < 97) return $urandom;
    if (r < 99) return '0;
    return '1 - $urandom_range(7);
  endfunction

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned      done_items;
    int unsigned      r;
    logic [KEY_W-1:0] k;
    idle_pct  = idle;
    stall_pct = stall;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    done_items = 0;
    while (done_items < PHASE_ITEMS) begin
      r = $urandom_range(199);
      k = pick_key();
      if (r < 2) begin
        send_item(KIND_CLR, k, $urandom);
      end else if (r < 6) begin
        send_item(KIND_UNUSED, k, $urandom);
        continue;
      end else if (r < 110) begin
        send_item(KIND_INC, k, pick_amount());
      end else begin
        send_item(KIND_EST, k, $urandom);
      end
      done_items++;
      // hold off mid-phase until every outstanding estimate is back
      if (done_items == PHASE_ITEMS / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    idle_pct     = 0;
    stall_pct    = 0;
    n_inc        = 0;
    n_clr        = 0;
    n_skip       = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= KIND_INC;
    in_ch.key    <= '0;
    in_ch.amount <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(KIND_EST, 64'h0123_4567_89AB_CDEF, '0);   // empty table
    send_item(KIND_INC, '0, 32'd1);
    send_item(KIND_INC, '0, '0);
    send_item(KIND_EST, '0, '1);
    send_item(KIND_INC, '1, '1);
    send_item(KIND_INC, '1, 32'd5);                     // already at max
    send_item(KIND_EST, '1, '0);
    send_item(KIND_INC, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_item(KIND_INC, 64'h8000_0000_0000_0000, 32'h8000_0000);  // sum hits 2^32
    send_item(KIND_EST, 64'h8000_0000_0000_0000, '0);
    send_item(KIND_INC, 64'h0000_0000_0000_00FF, 32'd7);  // byte order of the hash
    send_item(KIND_INC, 64'hFF00_0000_0000_0000, 32'd9);
    send_item(KIND_EST, 64'h0000_0000_0000_00FF, '0);
    send_item(KIND_EST, 64'hFF00_0000_0000_0000, '0);
    send_item(KIND_UNUSED, '1, '1);
    send_item(KIND_EST, '0, '0);
    send_item(KIND_CLR, '0, '0);
    send_item(KIND_EST, '1, '0);
    send_item(KIND_EST, 64'h8000_0000_0000_0000, '0);
    send_item(KIND_INC, '0, 32'hFFFF_FFFE);
    send_item(KIND_EST, '0, '0);
    wait_drained();

    run_phase(0, 0);
    run_phase(62, 0);
    run_phase(0, 62);
    run_phase(6, 6);

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Covered %0d increments, %0d clears, %0d ignored kind-3 transactions, %0d estimates.",
             n_inc, n_clr, n_skip, checked);
    $display("Phases: no idling, sender idle 62%%, receiver stall 62%%, both 6%%.");
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // 20 ms, several times the slowest expected run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
